// File: rtl/dmxrdm_pkg.sv
// Shared types and constants for the DMX512 / RDM frame receiver.
// No dependencies; imported by dmxrdm_engine and dmx512_rdm_frame_receiver.
`default_nettype none

package dmxrdm_pkg;

   // Frame size limits
   localparam int MAX_SLOTS        = 512;
   localparam int RDM_BUFFER_BYTES = 256;
   localparam int IDX_W            = 10;

   // Line event codes
   localparam logic [1:0] CMD_BREAK   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   // Store kinds
   localparam logic [1:0] STORE_NONE = 2'd0;
   localparam logic [1:0] STORE_DMX  = 2'd1;
   localparam logic [1:0] STORE_RDM  = 2'd2;

   // Frame events
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_DMX_DONE = 2'd1;
   localparam logic [1:0] EV_RDM_OK   = 2'd2;
   localparam logic [1:0] EV_RDM_DROP = 2'd3;

   // Protocol bytes
   localparam logic [7:0] SC_DMX        = 8'h00;
   localparam logic [7:0] SC_RDM        = 8'hCC;
   localparam logic [7:0] SUB_START_RDM = 8'h01;
   localparam logic [7:0] DISC_PREAMBLE = 8'hFE;
   localparam logic [7:0] DISC_SEPARATE = 8'hAA;
   localparam logic [IDX_W-1:0] DISC_PRE_END  = 10'd9;
   localparam logic [4:0]       DISC_EUID_LEN = 5'd12;
   localparam logic [4:0]       DISC_CS_LEN   = 5'd4;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_PRE_BREAK = 4'd1,
      PH_BREAK     = 4'd2,
      PH_DMX       = 4'd3,
      PH_RDM       = 4'd4,
      PH_CSH       = 4'd5,
      PH_CSL       = 4'd6,
      PH_DISC_FE   = 4'd7,
      PH_DISC_EUID = 4'd8,
      PH_DISC_CS   = 4'd9
   } phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  rx_byte;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [1:0]       store_kind;
      logic [IDX_W-1:0] slot_index;
      logic [7:0]       slot_data;
      logic [1:0]       frame_event;
      logic [IDX_W-1:0] slots_in_packet;
      logic [31:0]      slot_to_slot_us;
      logic [31:0]      break_to_break_us;
      logic             break_to_break_valid;
      logic [31:0]      dmx_packet_count;
      logic [31:0]      rdm_packet_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/dmxrdm_engine.sv
// Framing state machine and statistics for the DMX512 / RDM receiver.
// Depends on dmxrdm_pkg; updates its state once per step and forms the result.
`default_nettype none

module dmxrdm_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire dmxrdm_pkg::req_type ev,
   output dmxrdm_pkg::rsp_type    res
);
   import dmxrdm_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      last_t_ff, last_t_in;
   logic [31:0]      brk_latest_ff, brk_latest_in;
   logic [31:0]      brk_prev_ff, brk_prev_in;
   logic             brk_seen_ff, brk_seen_in;
   logic [31:0]      slot_int_ff, slot_int_in;
   logic [31:0]      brk_int_ff, brk_int_in;
   logic             brk_int_vld_ff, brk_int_vld_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       sub_ff, sub_in;
   logic [4:0]       disc_ff, disc_in;
   logic [31:0]      dmx_cnt_ff, dmx_cnt_in;
   logic [31:0]      rdm_cnt_ff, rdm_cnt_in;

   logic [IDX_W-1:0] idx_inc;
   logic [31:0]      gap;
   logic [4:0]       disc_inc;
   logic [1:0]       kind;
   logic [IDX_W-1:0] sidx;
   logic [7:0]       sdata;
   logic [1:0]       fev;
   logic [IDX_W-1:0] slots;

   assign idx_inc  = idx_ff + 10'd1;
   assign gap      = ev.time_us - last_t_ff;
   assign disc_inc = disc_ff + 5'd1;

   // Next state and result for one line event
   always_comb begin
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      last_t_in      = last_t_ff;
      brk_latest_in  = brk_latest_ff;
      brk_prev_in    = brk_prev_ff;
      brk_seen_in    = brk_seen_ff;
      slot_int_in    = slot_int_ff;
      brk_int_in     = brk_int_ff;
      brk_int_vld_in = brk_int_vld_ff;
      sum_in         = sum_ff;
      len_in         = len_ff;
      sub_in         = sub_ff;
      disc_in        = disc_ff;
      dmx_cnt_in     = dmx_cnt_ff;
      rdm_cnt_in     = rdm_cnt_ff;
      kind           = STORE_NONE;
      sidx           = '0;
      sdata          = '0;
      fev            = EV_NONE;
      slots          = '0;

      case (ev.cmd)
         CMD_BREAK: begin
            phase_in      = PH_PRE_BREAK;
            brk_latest_in = ev.time_us;
            last_t_in     = ev.time_us;
         end
         CMD_BYTE: begin
            last_t_in = ev.time_us;
            case (phase_ff)
               PH_IDLE: begin
                  if (ev.rx_byte == DISC_PREAMBLE) begin
                     phase_in = PH_DISC_FE;
                     kind     = STORE_RDM;
                     sdata    = DISC_PREAMBLE;
                     idx_in   = 10'd1;
                  end
               end
               PH_PRE_BREAK: begin
                  // skip the break's own zero byte
                  phase_in = PH_BREAK;
               end
               PH_BREAK: begin
                  if (ev.rx_byte == SC_DMX) begin
                     phase_in   = PH_DMX;
                     kind       = STORE_DMX;
                     idx_in     = 10'd1;
                     dmx_cnt_in = dmx_cnt_ff + 32'd1;
                     if (brk_seen_ff) begin
                        brk_int_in     = brk_latest_ff - brk_prev_ff;
                        brk_int_vld_in = 1'b1;
                     end else begin
                        brk_seen_in = 1'b1;
                     end
                     brk_prev_in = brk_latest_ff;
                  end else if (ev.rx_byte == SC_RDM) begin
                     phase_in       = PH_RDM;
                     kind           = STORE_RDM;
                     sdata          = SC_RDM;
                     sum_in         = {8'd0, SC_RDM};
                     idx_in         = 10'd1;
                     rdm_cnt_in     = rdm_cnt_ff + 32'd1;
                     brk_seen_in    = 1'b0;
                     brk_int_vld_in = 1'b0;
                  end else begin
                     phase_in       = PH_IDLE;
                     brk_seen_in    = 1'b0;
                     brk_int_vld_in = 1'b0;
                  end
               end
               PH_DMX: begin
                  slot_int_in = gap;
                  kind        = STORE_DMX;
                  sidx        = idx_ff;
                  sdata       = ev.rx_byte;
                  idx_in      = idx_inc;
                  if (idx_inc > IDX_W'(MAX_SLOTS)) begin
                     phase_in = PH_IDLE;
                     fev      = EV_DMX_DONE;
                     slots    = IDX_W'(MAX_SLOTS);
                  end
               end
               PH_RDM: begin
                  if (idx_ff >= IDX_W'(RDM_BUFFER_BYTES)) begin
                     phase_in = PH_IDLE;
                     fev      = EV_RDM_DROP;
                  end else begin
                     kind   = STORE_RDM;
                     sidx   = idx_ff;
                     sdata  = ev.rx_byte;
                     if (idx_ff == 10'd1) sub_in = ev.rx_byte;
                     if (idx_ff == 10'd2) len_in = ev.rx_byte;
                     sum_in = sum_ff + {8'd0, ev.rx_byte};
                     idx_in = idx_inc;
                     if (idx_inc >= 10'd3 && idx_inc == {2'd0, len_in}) phase_in = PH_CSH;
                  end
               end
               PH_CSH, PH_CSL: begin
                  if (idx_ff >= IDX_W'(RDM_BUFFER_BYTES)) begin
                     phase_in = PH_IDLE;
                     fev      = EV_RDM_DROP;
                  end else begin
                     kind   = STORE_RDM;
                     sidx   = idx_ff;
                     sdata  = ev.rx_byte;
                     idx_in = idx_inc;
                     if (phase_ff == PH_CSH) begin
                        sum_in   = sum_ff - {ev.rx_byte, 8'd0};
                        phase_in = PH_CSL;
                     end else begin
                        sum_in   = sum_ff - {8'd0, ev.rx_byte};
                        fev      = (sum_in == 16'd0 && sub_ff == SUB_START_RDM) ?
                                   EV_RDM_OK : EV_RDM_DROP;
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_DISC_FE: begin
                  kind   = STORE_RDM;
                  sidx   = idx_ff;
                  sdata  = ev.rx_byte;
                  idx_in = idx_inc;
                  if (ev.rx_byte == DISC_SEPARATE || idx_inc == DISC_PRE_END) begin
                     phase_in = PH_DISC_EUID;
                     disc_in  = '0;
                  end
               end
               PH_DISC_EUID: begin
                  kind    = STORE_RDM;
                  sidx    = idx_ff;
                  sdata   = ev.rx_byte;
                  idx_in  = idx_inc;
                  disc_in = disc_inc;
                  if (disc_inc == DISC_EUID_LEN) begin
                     phase_in = PH_DISC_CS;
                     disc_in  = '0;
                  end
               end
               PH_DISC_CS: begin
                  kind    = STORE_RDM;
                  sidx    = idx_ff;
                  sdata   = ev.rx_byte;
                  idx_in  = idx_inc;
                  disc_in = disc_inc;
                  if (disc_inc == DISC_CS_LEN) begin
                     phase_in = PH_IDLE;
                     fev      = EV_RDM_OK;
                  end
               end
               default: begin
                  phase_in       = PH_IDLE;
                  brk_seen_in    = 1'b0;
                  brk_int_vld_in = 1'b0;
               end
            endcase
         end
         CMD_TIMEOUT: begin
            // end the DMX frame once the line has been quiet too long
            if (phase_ff == PH_DMX && gap > slot_int_ff) begin
               phase_in = PH_IDLE;
               fev      = EV_DMX_DONE;
               slots    = idx_ff - 10'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // Assemble the result from the updated state
   always_comb begin
      res.store_kind           = kind;
      res.slot_index           = sidx;
      res.slot_data            = sdata;
      res.frame_event          = fev;
      res.slots_in_packet      = slots;
      res.slot_to_slot_us      = slot_int_in;
      res.break_to_break_us    = brk_int_in;
      res.break_to_break_valid = brk_int_vld_in;
      res.dmx_packet_count     = dmx_cnt_in;
      res.rdm_packet_count     = rdm_cnt_in;
   end

   // Hold state between events; advance on each step
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         idx_ff         <= '0;
         last_t_ff      <= '0;
         brk_latest_ff  <= '0;
         brk_prev_ff    <= '0;
         brk_seen_ff    <= 1'b0;
         slot_int_ff    <= '0;
         brk_int_ff     <= '0;
         brk_int_vld_ff <= 1'b0;
         sum_ff         <= '0;
         len_ff         <= '0;
         sub_ff         <= '0;
         disc_ff        <= '0;
         dmx_cnt_ff     <= '0;
         rdm_cnt_ff     <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         idx_ff         <= idx_in;
         last_t_ff      <= last_t_in;
         brk_latest_ff  <= brk_latest_in;
         brk_prev_ff    <= brk_prev_in;
         brk_seen_ff    <= brk_seen_in;
         slot_int_ff    <= slot_int_in;
         brk_int_ff     <= brk_int_in;
         brk_int_vld_ff <= brk_int_vld_in;
         sum_ff         <= sum_in;
         len_ff         <= len_in;
         sub_ff         <= sub_in;
         disc_ff        <= disc_in;
         dmx_cnt_ff     <= dmx_cnt_in;
         rdm_cnt_ff     <= rdm_cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_brk_valid_needs_seen: assert property (@(posedge clock) disable iff (reset)
      brk_int_vld_ff |-> brk_seen_ff)
      else $error("break interval valid without a previous break");

   a_euid_count_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DISC_EUID) |-> (disc_ff < DISC_EUID_LEN))
      else $error("EUID byte count out of range");

   a_counters_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(dmx_cnt_ff) && $stable(rdm_cnt_ff) && $stable(phase_ff))
      else $error("state moved without a step");

   a_dmx_index_range: assert property (@(posedge clock) disable iff (reset)
      (step && kind == STORE_DMX) |-> (sidx < IDX_W'(MAX_SLOTS + 1)))
      else $error("DMX slot index beyond frame");
`endif

endmodule

`default_nettype wire

// File: rtl/dmx512_rdm_frame_receiver.sv
// An accepted event waits in req_ff until it fires; its result is registered in rsp_ff.
// Throughput: one line event per cycle unless the result stalls; framing updates once per event.
// A waiting result stalls input only once the input register also holds an event.
// Reset (synchronous, active high) returns framing to idle and clears all statistics.
// Depends on dmxrdm_pkg and dmxrdm_engine.
`default_nettype none

module dmx512_rdm_frame_receiver (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire dmxrdm_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output dmxrdm_pkg::rsp_type      rsp_data
);
   import dmxrdm_pkg::*;

   req_type req_ff;
   logic    req_vld_ff, req_vld_in;
   rsp_type rsp_ff;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type eng_res;
   logic    fire;

   // Process the held event when the result register is free or draining
   assign fire      = req_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !req_vld_ff || fire;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   dmxrdm_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .ev    (req_ff),
      .res   (eng_res)
   );

   // Track occupancy of both registers
   always_comb begin
      req_vld_in = req_vld_ff;
      if (fire)      req_vld_in = 1'b0;
      if (req_valid && req_ready) req_vld_in = 1'b1;
      rsp_vld_in = rsp_vld_ff;
      if (rsp_vld_ff && rsp_ready) rsp_vld_in = 1'b0;
      if (fire) rsp_vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Capture payloads on transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      if (fire) rsp_ff <= eng_res;
   end

`ifndef SYNTHESIS
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && !fire) |=> req_vld_ff && $stable(req_ff))
      else $error("held event lost while stalled");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ready) |-> !fire)
      else $error("result overwritten before transfer");

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_vld_ff)
      else $error("processed event produced no result");
`endif

endmodule

`default_nettype wire
